### src/lsdm_pkg.sv
// Shared types and constants of the load/store data memory.
// Holds the request and result beat structs, operation and status codes,
// and the command/status structs between the controller and the datapath.
package lsdm_pkg;

  // Default depth of the word store, in 32-bit words.
  localparam int unsigned LSDM_MEM_WORDS = 4096;

  typedef enum logic [2:0] {
    OP_LW  = 3'd0,
    OP_LH  = 3'd1,
    OP_LHU = 3'd2,
    OP_LB  = 3'd3,
    OP_LBU = 3'd4,
    OP_SW  = 3'd5,
    OP_SH  = 3'd6,
    OP_SB  = 3'd7
  } lsdm_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_MISALIGN = 2'd2
  } lsdm_status_t;

  typedef struct packed {
    lsdm_op_t           req_type;
    logic        [31:0] base_address;
    logic signed [15:0] offset;
    logic        [31:0] write_data;
  } lsdm_req_t;

  typedef struct packed {
    logic         [31:0] read_data;
    lsdm_status_t        status;
  } lsdm_resp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic calc;
    logic read;
    logic finish;
  } lsdm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
  } lsdm_stat_t;

endpackage

### src/lsdm_ctrl.sv
// Controller state machine of the load/store data memory.
// Sequences the clearing pass and the four steps of each request.
// Depends on lsdm_pkg for the command and status structs.
module lsdm_ctrl
  import lsdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lsdm_stat_t stat,
  output lsdm_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ADDR  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } lsdm_state_t;

  lsdm_state_t state;
  lsdm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // The final lane-select or read-modify-write step always follows the memory read step.
  a_finish_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(cmd.read))
    else $error("finish issued without a preceding read");

  // The clearing pass is not left before the last word is cleared.
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && !stat.clear_done |=> (state == S_CLEAR))
    else $error("clearing pass left early");

  // Exactly one state bit is set at all times.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register lost its one-hot encoding");

endmodule

### src/lsdm_datapath.sv
// Datapath of the load/store data memory: request register, address adder,
// range and alignment checks, the word store and the load/store lane logic.
// Depends on lsdm_pkg for the beat structs and the operation codes.
module lsdm_datapath
  import lsdm_pkg::*;
#(
  parameter int unsigned MEM_WORDS = LSDM_MEM_WORDS
) (
  input  logic       clk,
  input  logic       rst,
  input  lsdm_cmd_t  cmd,
  input  lsdm_req_t  request,
  output lsdm_stat_t stat,
  output logic       done,
  output lsdm_resp_t result
);

  localparam int unsigned IDX_W    = $clog2(MEM_WORDS);
  localparam logic [31:0] END_ADDR = 32'(MEM_WORDS * 4);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

  logic [31:0] mem [MEM_WORDS];

  lsdm_req_t    req_q;
  logic [31:0]  ea_q;
  lsdm_status_t st_q;
  lsdm_status_t st_calc;
  logic [31:0]  rdata_q;
  logic [IDX_W-1:0] clr_cnt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [31:0]      rd_val;
  logic [31:0]      new_word;
  logic             is_store;
  logic [7:0]       byte_v;
  logic [15:0]      half_v;
  logic [IDX_W-1:0] word_idx;

  assign word_idx        = ea_q[IDX_W+1:2];
  assign stat.clear_done = (clr_cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
    if (cmd.calc) begin
      ea_q <= req_q.base_address + {{16{req_q.offset[15]}}, req_q.offset};
    end
    if (cmd.read) begin
      st_q <= st_calc;
    end
  end

  // The range test comes before the alignment test.
  always_comb begin
    st_calc = ST_OK;
    if (ea_q[31] || (ea_q >= END_ADDR)) begin
      st_calc = ST_RANGE;
    end else if ((req_q.req_type inside {OP_LW, OP_SW}) && (ea_q[1:0] != 2'b00)) begin
      st_calc = ST_MISALIGN;
    end else if ((req_q.req_type inside {OP_LH, OP_LHU, OP_SH}) && ea_q[0]) begin
      st_calc = ST_MISALIGN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata_q <= mem[word_idx];
    end
  end

  assign is_store = req_q.req_type inside {OP_SW, OP_SH, OP_SB};
  assign byte_v   = 8'(rdata_q >> {ea_q[1:0], 3'b000});
  assign half_v   = ea_q[1] ? rdata_q[31:16] : rdata_q[15:0];

  always_comb begin
    rd_val   = '0;
    new_word = rdata_q;
    case (req_q.req_type)
      OP_LW:  rd_val = rdata_q;
      OP_LH:  rd_val = {{16{half_v[15]}}, half_v};
      OP_LHU: rd_val = {16'h0000, half_v};
      OP_LB:  rd_val = {{24{byte_v[7]}}, byte_v};
      OP_LBU: rd_val = {24'h000000, byte_v};
      OP_SW:  new_word = req_q.write_data;
      OP_SH:  new_word[{ea_q[1], 4'b0000} +: 16] = req_q.write_data[15:0];
      OP_SB:  new_word[{ea_q[1:0], 3'b000} +: 8] = req_q.write_data[7:0];
      default: rd_val = '0;
    endcase
    if (st_q != ST_OK) begin
      rd_val = '0;
    end
  end

  // One write port, shared by the clearing pass and the store step.
  always_comb begin
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = cmd.finish && is_store && (st_q == ST_OK);
      wr_addr = word_idx;
      wr_data = new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_data <= rd_val;
      result.status    <= st_q;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> (result.read_data == 32'h0))
    else $error("failed access returned nonzero data");

  a_store_zero: assert property (@(posedge clk) disable iff (rst)
    done && ((req_q.req_type == OP_SW) || (req_q.req_type == OP_SH) ||
             (req_q.req_type == OP_SB)) |-> (result.read_data == 32'h0))
    else $error("store returned nonzero data");

endmodule

### src/load_store_data_memory.sv
// Top level of the load/store data memory.
// Instantiates lsdm_ctrl and lsdm_datapath; depends on lsdm_pkg.
//
// Byte-addressed, little-endian data memory of MEM_WORDS 32-bit words with
// a load/store command interface. After reset the block runs a clearing
// pass that writes zero to every word, one word per cycle, and busy stays
// high until the pass ends, so only then can the first request beat be taken.
// A request beat is taken on a rising edge where start is high and busy is
// low. Each request runs in four steps: registering the request, the 32-bit
// address add, the registered read of the single RAM port, and the lane
// select or read-modify-write that merges store bytes back through the same
// port. The result beat is on result for exactly one cycle, flagged by done,
// in the cycle after the last step; busy is already low in that cycle, so a
// new request can be taken while the result is shown. The receiver cannot
// hold results off, so it must capture result whenever done is high. An
// effective address that is negative or at or past the end of the memory
// reports an out-of-range status; a misaligned word or halfword access
// reports a misaligned status. In both cases nothing is written and
// read_data is zero. Stores always return zero read data.
module load_store_data_memory
  import lsdm_pkg::*;
#(
  parameter int unsigned MEM_WORDS = LSDM_MEM_WORDS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  lsdm_req_t  request,
  output logic       done,
  output lsdm_resp_t result
);

  // Command and status structs are the only link between the two halves.
  lsdm_cmd_t  cmd;
  lsdm_stat_t stat;

  lsdm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lsdm_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

### bench/lsdm_checker.sv
// Checker for the load/store data memory: mirrors the word store, predicts one
// result beat per accepted request and compares it with what the block returns.
// Depends on lsdm_pkg for the request, result, operation and status types.
module lsdm_checker
  import lsdm_pkg::*;
#(
  parameter int unsigned MEM_WORDS = LSDM_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  lsdm_req_t   request,
  input  logic        done,
  input  lsdm_resp_t  result,
  output int unsigned errors,
  output int unsigned outstanding,
  output int unsigned compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_BYTES = MEM_WORDS * 4;
  localparam int unsigned IDX_W     = $clog2(MEM_WORDS);

  logic [31:0] mirror_words [MEM_WORDS];
  lsdm_resp_t  expected_results [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    compared    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    errors++;
  endtask

  // Applies one request to the mirror and returns the result beat it should give.
  task automatic mirror_access(input lsdm_req_t r, output lsdm_resp_t rsp);
    logic [31:0]      ea;
    logic [31:0]      word;
    logic [15:0]      half;
    logic [7:0]       b8;
    int unsigned      size;
    logic [IDX_W-1:0] idx;
    int unsigned      sh;
    ea = r.base_address + {{16{r.offset[15]}}, r.offset};
    case (r.req_type)
      OP_LW, OP_SW:         size = 4;
      OP_LH, OP_LHU, OP_SH: size = 2;
      default:              size = 1;
    endcase
    rsp.read_data = '0;
    rsp.status    = ST_OK;
    if (ea[31] || ea >= MEM_BYTES) begin
      rsp.status = ST_RANGE;
    end else if ((ea & (size - 1)) != 0) begin
      rsp.status = ST_MISALIGN;
    end else begin
      idx  = ea[IDX_W+1:2];
      sh   = 8 * ea[1:0];
      word = mirror_words[idx];
      half = 16'(word >> sh);
      b8   = 8'(word >> sh);
      case (r.req_type)
        OP_LW:  rsp.read_data = word;
        OP_LH:  rsp.read_data = {{16{half[15]}}, half};
        OP_LHU: rsp.read_data = {16'h0000, half};
        OP_LB:  rsp.read_data = {{24{b8[7]}}, b8};
        OP_LBU: rsp.read_data = {24'h000000, b8};
        OP_SW:  mirror_words[idx] = r.write_data;
        OP_SH:  mirror_words[idx] = (word & ~(32'h0000_FFFF << sh)) |
                                    ({16'h0000, r.write_data[15:0]} << sh);
        default: mirror_words[idx] = (word & ~(32'h0000_00FF << sh)) |
                                     ({24'h000000, r.write_data[7:0]} << sh);
      endcase
    end
  endtask

  always @(posedge clk) begin
    lsdm_resp_t want;
    if (rst) begin
      foreach (mirror_words[i]) mirror_words[i] = '0;
      expected_results.delete();
    end else begin
      // A result beat belongs to an earlier request, so it is retired first.
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no request outstanding", result.read_data, '0);
        end else begin
          want = expected_results.pop_front();
          compared++;
          if (result.read_data !== want.read_data)
            report_mismatch("read_data", result.read_data, want.read_data);
          if (result.status !== want.status)
            report_mismatch("status", 32'(result.status), 32'(want.status));
        end
      end
      if (start && !busy) begin
        mirror_access(request, want);
        expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### bench/tb.sv
// Top of the load/store data memory testbench: clock, reset, request stimulus
// and the verdict. Depends on lsdm_pkg, load_store_data_memory and lsdm_checker.
module tb;
  import lsdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS    = LSDM_MEM_WORDS;
  localparam int unsigned MEM_BYTES    = MEM_WORDS * 4;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned REQ_W        = $bits(lsdm_req_t);

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  lsdm_req_t  request;
  logic       done;
  lsdm_resp_t result;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned op_count [8];
  int unsigned directed_beats;

  load_store_data_memory #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // The checker sits beside the block and sees exactly the same pins.
  lsdm_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .errors     (errors),
    .outstanding(outstanding),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Issues one request beat and returns on the edge that accepted it. Start
  // is left high, so a back-to-back beat simply overwrites the request and
  // the caller decides whether to drop start for a gap.
  task automatic send(input lsdm_op_t op, input logic [31:0] base,
                      input logic [15:0] off, input logic [31:0] wd);
    lsdm_req_t r;
    r.req_type     = op;
    r.base_address = base;
    r.offset       = off;
    r.write_data   = wd;
    start   <= 1'b1;
    request <= r;
    op_count[op]++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle for a number of cycles with start low. The request lines carry junk
  // meanwhile, which the block must ignore.
  task automatic idle(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      request <= REQ_W'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
  endtask

  // Picks a random request. Most beats land aligned in two small windows at
  // the bottom and top of memory, so loads read back earlier stores. The rest
  // are misaligned lanes, addresses past the end or negative, and raw noise.
  task automatic send_random();
    lsdm_op_t    op;
    int unsigned size;
    int unsigned pick;
    int unsigned word;
    logic [31:0] ea;
    logic [31:0] base;
    logic [15:0] off;
    op = lsdm_op_t'($urandom_range(int'(OP_SB), int'(OP_LW)));
    case (op)
      OP_LW, OP_SW:         size = 4;
      OP_LH, OP_LHU, OP_SH: size = 2;
      default:              size = 1;
    endcase
    pick = $urandom_range(99, 0);
    word = $urandom_range(1, 0) ? $urandom_range(31, 0)
                                : MEM_WORDS - 1 - $urandom_range(31, 0);
    off  = 16'($urandom);
    if (pick < 65) begin
      ea = {word[29:0], 2'b00} | ($urandom_range(3, 0) & ~(size - 1));
    end else if (pick < 80) begin
      // Any byte lane; word and halfword accesses are usually misaligned here.
      ea = {word[29:0], 2'b00} | $urandom_range(3, 0);
    end else if (pick < 92) begin
      case ($urandom_range(2, 0))
        0:       ea = MEM_BYTES;
        1:       ea = MEM_BYTES + $urandom_range(255, 0);
        default: ea = 32'h8000_0000 | $urandom;
      endcase
    end else begin
      ea = $urandom;
    end
    // Pick the base so that base plus the sign-extended offset hits the target.
    base = ea - {{16{off[15]}}, off};
    send(op, base, off, $urandom);
  endtask

  initial begin
    int unsigned burst;

    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    foreach (op_count[i]) op_count[i] = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first beat waits out the clearing pass on busy.
    // A word with every byte distinct and the sign bit of every byte set
    // exercises every extension path.
    send(OP_SW,  32'h0000_0000, 16'h0000, 32'h8081_82F3);
    send(OP_LW,  32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    send(OP_LH,  32'h0000_0000, 16'h0000, 32'h0000_0000);
    send(OP_LHU, 32'h0000_0002, 16'h0000, 32'h0000_0000);
    send(OP_LH,  32'h0000_0002, 16'h0000, 32'h0000_0000);
    send(OP_LB,  32'h0000_0000, 16'h0000, 32'h0000_0000);
    send(OP_LBU, 32'h0000_0001, 16'h0000, 32'h0000_0000);
    send(OP_LB,  32'h0000_0003, 16'h0000, 32'h0000_0000);
    // Partial stores must merge into a word that is otherwise zero.
    send(OP_SH,  32'h0000_0006, 16'h0000, 32'hDEAD_7F01);
    send(OP_SB,  32'h0000_0004, 16'h0000, 32'hFFFF_FF80);
    send(OP_LW,  32'h0000_0004, 16'h0000, 32'h0000_0000);
    send(OP_LBU, 32'h0000_0004, 16'h0000, 32'h0000_0000);
    // Last word of memory, reached through the most negative and -1 offsets.
    send(OP_SW,  32'h0000_BFFC, 16'h8000, 32'hFFFF_FFFF);
    send(OP_LW,  32'h0000_3FFD, 16'hFFFF, 32'h0000_0000);
    send(OP_LBU, 32'h0000_3FFF, 16'h0000, 32'h0000_0000);
    // The end address itself is out of range, for loads and stores alike.
    send(OP_LB,  MEM_BYTES,     16'h0000, 32'h0000_0000);
    send(OP_SB,  MEM_BYTES - 32'h7FFF, 16'h7FFF, 32'h0000_00AA);
    // Negative effective addresses, including one from a large base.
    send(OP_LW,  32'hFFFF_FFFC, 16'h0000, 32'h0000_0000);
    send(OP_SW,  32'h7FFF_FFFF, 16'h7FFF, 32'h1234_5678);
    // The add wraps modulo 2^32 back to address zero.
    send(OP_LW,  32'hFFFF_8001, 16'h7FFF, 32'h0000_0000);
    // Misaligned word and halfword accesses; a misaligned store must not write.
    send(OP_LW,  32'h0000_0001, 16'h0000, 32'h0000_0000);
    send(OP_SW,  32'h0000_0002, 16'h0000, 32'hCAFE_BABE);
    send(OP_LH,  32'h0000_0003, 16'h0000, 32'h0000_0000);
    send(OP_SH,  32'h0000_0001, 16'h0000, 32'hFFFF_FFFF);
    // Out of range takes priority over misalignment.
    send(OP_LW,  MEM_BYTES + 1, 16'h0000, 32'h0000_0000);
    send(OP_LW,  32'h0000_0000, 16'h0000, 32'h0000_0000);
    directed_beats = 26;

    // Random part in bursts. A zero gap keeps start high, so some bursts run
    // back to back; other gaps land on different phases of the request cycle.
    while (op_count.sum() < directed_beats + RANDOM_BEATS) begin
      burst = $urandom_range(12, 1);
      repeat (burst) send_random();
      if ($urandom_range(3, 0) != 0) idle($urandom_range(6, 1));
    end
    start <= 1'b0;

    // Drain: wait for the last result beat, then a few cycles more in case a
    // stray beat follows. The watchdog below bounds this wait.
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d request beats (%0d directed), %0d result beats compared.",
             op_count.sum(), directed_beats, compared);
    $display("Per op: lw %0d lh %0d lhu %0d lb %0d lbu %0d sw %0d sh %0d sb %0d",
             op_count[OP_LW], op_count[OP_LH], op_count[OP_LHU], op_count[OP_LB],
             op_count[OP_LBU], op_count[OP_SW], op_count[OP_SH], op_count[OP_SB]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: bounds the whole run, including the clearing pass, and fails it
  // if the run has not finished by then.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
src/lsdm_pkg.sv
src/lsdm_ctrl.sv
src/lsdm_datapath.sv
src/load_store_data_memory.sv
bench/lsdm_checker.sv
bench/tb.sv
